### rtl/core/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg: shared types and constants for the n-gram prefix count merger
// Beat payloads, queue entry, operation/status/register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

  localparam int InWords      = 6;   // word ids per input beat
  localparam int OutWords     = 5;   // word ids per result beat
  localparam int WordW        = 16;
  localparam int CountW       = 32;
  localparam int CfgW         = 3;   // widest config register
  localparam int CfgIdxW      = 1;
  localparam int MaxWordsDef  = 6;
  localparam int QueueDepthDef = 4;

  // input operation codes
  localparam logic OpRecord = 1'b0;
  localparam logic OpFlush  = 1'b1;

  // result status codes
  localparam logic StatusGroup    = 1'b0;
  localparam logic StatusOrderErr = 1'b1;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgNWords = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMWords = 1'b1;

  localparam logic [CfgW-1:0] NWordsRst = 3'd3;
  localparam logic [CfgW-1:0] MWordsRst = 3'd2;

  typedef enum logic {
    KindRecord = 1'b0,
    KindFlush  = 1'b1
  } npcm_kind_e;

  typedef struct packed {
    logic              operation;
    logic [WordW-1:0]  word_0;
    logic [WordW-1:0]  word_1;
    logic [WordW-1:0]  word_2;
    logic [WordW-1:0]  word_3;
    logic [WordW-1:0]  word_4;
    logic [WordW-1:0]  word_5;
    logic [CountW-1:0] occurrences;
  } npcm_rec_t;

  typedef struct packed {
    logic              status;
    logic [WordW-1:0]  gram_word_0;
    logic [WordW-1:0]  gram_word_1;
    logic [WordW-1:0]  gram_word_2;
    logic [WordW-1:0]  gram_word_3;
    logic [WordW-1:0]  gram_word_4;
    logic [CountW-1:0] group_total;
  } npcm_res_t;

  // classified item handed from front to back
  typedef struct packed {
    npcm_kind_e                     kind;
    logic [InWords-1:0]             cmp_mask;  // positions in the order check
    logic [OutWords-1:0]            pre_mask;  // positions in the prefix
    logic [InWords-1:0][WordW-1:0]  words;
    logic [CountW-1:0]              count;
  } npcm_item_t;

endpackage

`default_nettype wire

### rtl/core/npcm_stream_if.sv
// ----------------------------------------------------------------------------
// npcm_stream_if: valid/ready stream channel
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface npcm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/npcm_queue.sv
// ----------------------------------------------------------------------------
// npcm_queue: small register FIFO between front and back
// Show-ahead read, full/empty from an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/npcm_front.sv
// ----------------------------------------------------------------------------
// npcm_front: config registers and input classification
// Decodes the operation and turns n/m into compare and prefix masks.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_front import npcm_pkg::*; #(
  parameter int MAX_WORDS = MaxWordsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  npcm_stream_if.sink             rec_i,
  output logic                    q_push_o,
  output npcm_item_t              q_item_o,
  input  wire logic               q_full_i
);

  logic [CfgW-1:0] n_words_q, n_words_d, m_words_q, m_words_d;
  logic [CfgW-1:0] eff_n, eff_m;
  npcm_rec_t rec;

  assign rec = rec_i.data;

  always_comb begin
    n_words_d = n_words_q;
    m_words_d = m_words_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNWords: n_words_d = cfg_wdata_i;
        CfgMWords: m_words_d = cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_words_q <= NWordsRst;
      m_words_q <= MWordsRst;
    end else begin
      n_words_q <= n_words_d;
      m_words_q <= m_words_d;
    end
  end

  // clamp: 2 <= n <= MAX_WORDS, 1 <= m <= n-1
  always_comb begin
    eff_n = n_words_q;
    if (eff_n > CfgW'(MAX_WORDS)) begin
      eff_n = CfgW'(MAX_WORDS);
    end
    if (eff_n < 3'd2) begin
      eff_n = 3'd2;
    end
    eff_m = m_words_q;
    if (eff_m >= eff_n) begin
      eff_m = eff_n - 3'd1;
    end
    if (eff_m == '0) begin
      eff_m = 3'd1;
    end
  end

  always_comb begin
    q_item_o = '0;
    unique case (rec.operation)
      OpRecord: q_item_o.kind = KindRecord;
      OpFlush:  q_item_o.kind = KindFlush;
      default:  q_item_o.kind = KindRecord;
    endcase
    for (int i = 0; i < InWords; i++) begin
      q_item_o.cmp_mask[i] = (CfgW'(i) < eff_n);
    end
    for (int i = 0; i < OutWords; i++) begin
      q_item_o.pre_mask[i] = (CfgW'(i) < eff_m);
    end
    q_item_o.words[0] = rec.word_0;
    q_item_o.words[1] = rec.word_1;
    q_item_o.words[2] = rec.word_2;
    q_item_o.words[3] = rec.word_3;
    q_item_o.words[4] = rec.word_4;
    q_item_o.words[5] = rec.word_5;
    q_item_o.count    = rec.occurrences;
  end

  assign q_push_o    = rec_i.valid;
  assign rec_i.ready = ~q_full_i;

endmodule

`default_nettype wire

### rtl/core/npcm_back.sv
// ----------------------------------------------------------------------------
// npcm_back: group state, order check, saturating total, result register
// Retires one queued item per cycle while the result slot can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_back import npcm_pkg::*; #(
  parameter int MAX_WORDS = MaxWordsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire npcm_item_t q_item_i,
  output logic            q_pop_o,
  npcm_stream_if.source res_o
);

  logic [MAX_WORDS-1:0][WordW-1:0] prev_q, prev_d;
  logic [InWords-1:0][WordW-1:0]   prev_ext;
  logic [CountW-1:0] sum_q, sum_d;
  logic [CountW:0]   sum_wide;
  logic have_q, have_d, halted_q, halted_d;
  logic res_valid_q, res_valid_d, res_load;
  npcm_res_t res_q, res_d, grp;
  logic order_err, decided, same;

  // slot free or draining this cycle
  assign q_pop_o = q_valid_i & (~res_valid_q | res_o.ready);

  for (genvar g = 0; g < InWords; g++) begin : g_prev
    if (g < MAX_WORDS) begin : g_kept
      assign prev_ext[g] = prev_q[g];
    end else begin : g_none
      assign prev_ext[g] = '0;
    end
  end

  // first differing compared position decides the order
  always_comb begin
    order_err = 1'b0;
    decided   = 1'b0;
    for (int i = 0; i < InWords; i++) begin
      if (q_item_i.cmp_mask[i] && !decided) begin
        if (q_item_i.words[i] < prev_ext[i]) begin
          order_err = 1'b1;
          decided   = 1'b1;
        end else if (q_item_i.words[i] > prev_ext[i]) begin
          decided = 1'b1;
        end
      end
    end
    same = 1'b1;
    for (int i = 0; i < OutWords; i++) begin
      if (q_item_i.pre_mask[i] && (q_item_i.words[i] != prev_ext[i])) begin
        same = 1'b0;
      end
    end
  end

  assign sum_wide = {1'b0, sum_q} + {1'b0, q_item_i.count};

  always_comb begin
    grp             = '0;
    grp.status      = StatusGroup;
    grp.gram_word_0 = q_item_i.pre_mask[0] ? prev_ext[0] : '0;
    grp.gram_word_1 = q_item_i.pre_mask[1] ? prev_ext[1] : '0;
    grp.gram_word_2 = q_item_i.pre_mask[2] ? prev_ext[2] : '0;
    grp.gram_word_3 = q_item_i.pre_mask[3] ? prev_ext[3] : '0;
    grp.gram_word_4 = q_item_i.pre_mask[4] ? prev_ext[4] : '0;
    grp.group_total = sum_q;
  end

  always_comb begin
    halted_d = halted_q;
    have_d   = have_q;
    sum_d    = sum_q;
    prev_d   = prev_q;
    res_load = 1'b0;
    res_d    = grp;
    if (q_pop_o && !halted_q) begin
      unique case (q_item_i.kind)
        KindFlush: begin
          if (have_q) begin
            res_load = 1'b1;
            have_d   = 1'b0;
            sum_d    = '0;
          end
        end
        KindRecord: begin
          if (!have_q) begin
            have_d = 1'b1;
            sum_d  = q_item_i.count;
            for (int i = 0; i < MAX_WORDS; i++) begin
              prev_d[i] = q_item_i.words[i];
            end
          end else if (order_err) begin
            res_load     = 1'b1;
            res_d        = '0;
            res_d.status = StatusOrderErr;
            halted_d     = 1'b1;
          end else begin
            for (int i = 0; i < MAX_WORDS; i++) begin
              prev_d[i] = q_item_i.words[i];
            end
            if (same) begin
              sum_d = sum_wide[CountW] ? '1 : sum_wide[CountW-1:0];
            end else begin
              res_load = 1'b1;
              sum_d    = q_item_i.count;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_valid_d = res_load | (res_valid_q & ~res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      halted_q    <= 1'b0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      have_q      <= have_d;
      halted_q    <= halted_d;
      sum_q       <= sum_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

`ifndef SYNTH
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  a_halt_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halted_q) |-> !$rose(res_valid_q))
    else $error("new result after order error");

  a_group_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(have_q) |-> $past(q_pop_o && q_item_i.kind == KindFlush))
    else $error("group closed by something other than a flush");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status == StatusOrderErr) |-> (res_q.group_total == '0))
    else $error("order error result carries a total");
`endif

endmodule

`default_nettype wire

### rtl/core/ngram_prefix_count_merger_core.sv
// ----------------------------------------------------------------------------
// ngram_prefix_count_merger_core: sorted n-gram stream reduced by m-id prefix
// Path: a taken record or flush beat is written into the queue; the back end
// then retires it into the result reg. Throughput: one beat per cycle while
// the queue has room; queue and result register decouple sides. Rate is set
// by the back end retiring one item per cycle while the result slot is free.
// Reset: async, active low; clears group state, halt flag, queue, n=3, m=2.
// ----------------------------------------------------------------------------
`default_nettype none

module ngram_prefix_count_merger_core import npcm_pkg::*; #(
  parameter int MAX_WORDS   = MaxWordsDef,   // 2..6 ids taking part in compares
  parameter int QUEUE_DEPTH = QueueDepthDef  // front-to-back queue entries
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  npcm_stream_if.sink             rec_i,
  npcm_stream_if.source           res_o
);

  // Front: holds n/m, classifies each input beat into a queue entry that
  // already carries its compare mask (first n ids) and prefix mask (first m).
  logic       f_push;
  npcm_item_t f_item;
  logic       q_full, q_empty, b_pop;
  logic [$bits(npcm_item_t)-1:0] q_rdata;
  npcm_item_t q_item;

  npcm_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_i       (rec_i),
    .q_push_o    (f_push),
    .q_item_o    (f_item),
    .q_full_i    (q_full)
  );

  // Queue: lets the input keep streaming while a result beat is stalled.
  npcm_queue #(
    .WIDTH ($bits(npcm_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_item),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign q_item = npcm_item_t'(q_rdata);

  // Back: previous record, running total, halt flag; order check against
  // the previous record, group emit on prefix change or flush. Result beats
  // sit in a register; the back end stalls only while one waits unaccepted,
  // and the queue absorbs input meanwhile.
  npcm_back #(
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (~q_empty),
    .q_item_i  (q_item),
    .q_pop_o   (b_pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

### tb/tb_ngram_prefix_count_merger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ngram_prefix_count_merger_core: self-checking bench for the prefix merger
// Feeds sorted n-gram record streams with random gaps and back-pressure,
// predicts each finished m-gram group (and the one order error), and compares
// every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_ngram_prefix_count_merger_core;
  import npcm_pkg::*;

  localparam int MAX_WORDS     = MaxWordsDef;
  localparam int QUEUE_DEPTH   = QueueDepthDef;
  // queue plus result register may still hold work that makes no result
  localparam int SettlePause   = 2 * QUEUE_DEPTH + 4;
  localparam int TimeoutCycles = 1_000_000;
  localparam int PhaseBeats    = 146;
  localparam int TablePhases   = 9;
  localparam int RandomPhases  = 3;

  // --------------------------------------------------------------------------
  // clock, reset, config port, channels
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  always #5 clk_i = ~clk_i;

  npcm_stream_if #(.payload_t(npcm_rec_t)) rec_if ();
  npcm_stream_if #(.payload_t(npcm_res_t)) res_if ();

  ngram_prefix_count_merger_core #(
    .MAX_WORDS   (MAX_WORDS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .rec_i       (rec_if),
    .res_o       (res_if)
  );

  // --------------------------------------------------------------------------
  // bench bookkeeping
  // --------------------------------------------------------------------------
  npcm_rec_t   record_backlog [$];   // beats waiting for the driver
  npcm_res_t   expected_grams [$];   // predicted result beats, oldest first
  int unsigned beats_queued     = 0;
  int unsigned beats_sent       = 0;
  int unsigned grams_seen       = 0;
  int unsigned bad_grams        = 0;
  int unsigned settings_applied = 0;
  bit          draining         = 1'b0;

  // bench copy of the two registers (reset values)
  logic [CfgW-1:0] n_setting = NWordsRst;
  logic [CfgW-1:0] m_setting = MWordsRst;

  // predicted merger state
  logic [WordW-1:0]  last_words [InWords] = '{default: '0};
  logic [CountW-1:0] group_sum     = '0;
  bit                have_group    = 1'b0;
  bit                stream_halted = 1'b0;

  // stimulus generator cursor: last record it produced in the open stream
  logic [WordW-1:0] gen_words [InWords] = '{default: '0};
  bit               gen_open = 1'b0;

  // register table for the first phases; extremes and out-of-range values
  int n_plan [TablePhases] = '{2, 6, 0, 7, 1, 6, 4, 5, 3};
  int m_plan [TablePhases] = '{1, 5, 0, 7, 6, 1, 4, 2, 1};

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  // n clamps into 2..MAX_WORDS
  function automatic int eff_n_words();
    int n;
    n = int'(n_setting);
    if (n < 2) n = 2;
    if (n > MAX_WORDS) n = MAX_WORDS;
    return n;
  endfunction

  // m clamps into 1..n-1, and never past the result width
  function automatic int eff_m_words(input int n);
    int m;
    m = int'(m_setting);
    if (m >= n) m = n - 1;
    if (m < 1) m = 1;
    if (m > OutWords) m = OutWords;
    return m;
  endfunction

  // finished m-gram of the last record, ids past m forced to zero
  function automatic npcm_res_t close_group(input int m);
    npcm_res_t g;
    g             = '0;
    g.status      = StatusGroup;
    g.gram_word_0 = last_words[0];
    g.gram_word_1 = (m > 1) ? last_words[1] : '0;
    g.gram_word_2 = (m > 2) ? last_words[2] : '0;
    g.gram_word_3 = (m > 3) ? last_words[3] : '0;
    g.gram_word_4 = (m > 4) ? last_words[4] : '0;
    g.group_total = group_sum;
    return g;
  endfunction

  // folds one accepted record/flush beat into the predicted state
  task automatic merge_beat(input npcm_rec_t beat);
    logic [WordW-1:0]  cur [InWords];
    logic [CountW:0]   wide_sum;
    npcm_res_t         err;
    int                n, m;
    bit                decided, order_err, same_prefix;
    n = eff_n_words();
    m = eff_m_words(n);
    if (stream_halted) return;   // dead until reset
    if (beat.operation == OpFlush) begin
      if (have_group) begin
        expected_grams.push_back(close_group(m));
        have_group = 1'b0;
        group_sum  = '0;
      end
      return;
    end
    cur[0] = beat.word_0;
    cur[1] = beat.word_1;
    cur[2] = beat.word_2;
    cur[3] = beat.word_3;
    cur[4] = beat.word_4;
    cur[5] = beat.word_5;
    if (!have_group) begin
      last_words = cur;
      group_sum  = beat.occurrences;
      have_group = 1'b1;
      return;
    end
    // lexicographic order over the first n ids only
    decided   = 1'b0;
    order_err = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!decided) begin
        if (cur[i] < last_words[i]) begin
          order_err = 1'b1;
          decided   = 1'b1;
        end else if (cur[i] > last_words[i]) begin
          decided = 1'b1;
        end
      end
    end
    if (order_err) begin
      err        = '0;
      err.status = StatusOrderErr;
      expected_grams.push_back(err);
      stream_halted = 1'b1;
      return;
    end
    same_prefix = 1'b1;
    for (int i = 0; i < m; i++)
      if (cur[i] != last_words[i]) same_prefix = 1'b0;
    if (same_prefix) begin
      wide_sum  = {1'b0, group_sum} + {1'b0, beat.occurrences};
      group_sum = wide_sum[CountW] ? '1 : wide_sum[CountW-1:0];
    end else begin
      expected_grams.push_back(close_group(m));
      group_sum = beat.occurrences;
    end
    last_words = cur;
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  function automatic string gram_text(input npcm_res_t r);
    return $sformatf("status=%0d ids=%h,%h,%h,%h,%h total=%h", r.status,
                     r.gram_word_0, r.gram_word_1, r.gram_word_2,
                     r.gram_word_3, r.gram_word_4, r.group_total);
  endfunction

  task automatic check_gram(input npcm_res_t got);
    npcm_res_t want;
    grams_seen++;
    if (expected_grams.size() == 0) begin
      bad_grams++;
      if (bad_grams <= 10)
        $display("[%0t] ERROR: result with nothing pending: %s", $realtime, gram_text(got));
      return;
    end
    want = expected_grams.pop_front();
    if (got.status      !== want.status      ||
        got.gram_word_0 !== want.gram_word_0 ||
        got.gram_word_1 !== want.gram_word_1 ||
        got.gram_word_2 !== want.gram_word_2 ||
        got.gram_word_3 !== want.gram_word_3 ||
        got.gram_word_4 !== want.gram_word_4 ||
        got.group_total !== want.group_total) begin
      bad_grams++;
      if (bad_grams <= 10) begin
        $display("[%0t] ERROR: result beat %0d differs", $realtime, grams_seen);
        $display("    expected %s", gram_text(want));
        $display("    actual   %s", gram_text(got));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // idle/stall lengths: mostly short, a few long, with calm stretches of none
  // --------------------------------------------------------------------------
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // --------------------------------------------------------------------------
  // driver: record channel, fed from the backlog
  // --------------------------------------------------------------------------
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_if.valid <= 1'b0;
      rec_if.data  <= '0;
      send_gap     = 0;
    end else begin
      // accepted beat: predict before counting it, the idle check relies on it
      if (rec_if.valid && rec_if.ready) begin
        merge_beat(rec_if.data);
        beats_sent++;
      end
      if (!rec_if.valid || rec_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          rec_if.valid <= 1'b0;
        end else if (record_backlog.size() != 0) begin
          rec_if.data  <= record_backlog.pop_front();
          rec_if.valid <= 1'b1;
          send_gap     = next_gap(send_calm);
        end else begin
          rec_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: result channel with random back-pressure
  // --------------------------------------------------------------------------
  int take_stall = 0;
  int take_calm  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      take_stall   = 0;
    end else begin
      if (res_if.valid && res_if.ready) check_gram(res_if.data);
      if (draining) begin
        res_if.ready <= 1'b1;   // catch any stray beat at the end
      end else if (take_stall > 0) begin
        take_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        take_stall   = next_gap(take_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic npcm_rec_t record_beat(
    input logic [WordW-1:0] w0, w1, w2, w3, w4, w5,
    input logic [CountW-1:0] occ
  );
    npcm_rec_t b;
    b.operation   = OpRecord;
    b.word_0      = w0;
    b.word_1      = w1;
    b.word_2      = w2;
    b.word_3      = w3;
    b.word_4      = w4;
    b.word_5      = w5;
    b.occurrences = occ;
    return b;
  endfunction

  // flush payload is don't-care, so randomize it
  function automatic npcm_rec_t flush_beat();
    npcm_rec_t b;
    b           = record_beat(WordW'($urandom), WordW'($urandom), WordW'($urandom),
                              WordW'($urandom), WordW'($urandom), WordW'($urandom),
                              $urandom);
    b.operation = OpFlush;
    return b;
  endfunction

  task automatic queue_beat(input npcm_rec_t b);
    record_backlog.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_cursor(input logic [CountW-1:0] occ);
    queue_beat(record_beat(gen_words[0], gen_words[1], gen_words[2],
                           gen_words[3], gen_words[4], gen_words[5], occ));
  endtask

  function automatic logic [WordW-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return WordW'($urandom_range(0, 16'hFFFF));
  endfunction

  // small counts, full-range counts, and counts near max to hit saturation
  function automatic logic [CountW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 1000);
    if (r < 85) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 16);
  endfunction

  // next record of the open stream: never below the cursor at any n
  task automatic advance_cursor(input int n, input int m);
    int p, lo, hi, r;
    if ($urandom_range(0, 99) < 8) return;   // exact repeat
    r = $urandom_range(0, 99);
    if (r < 30)
      p = $urandom_range(0, m - 1);          // new group
    else if (r < 38 && n < InWords)
      p = $urandom_range(n, InWords - 1);    // only ignored ids move
    else
      p = $urandom_range(m, n - 1);          // same group, new record
    if (gen_words[p] == '1) return;          // no room, repeat instead
    lo = gen_words[p] + 1;
    hi = $urandom_range(0, 1) ? 16'hFFFF : ((lo + 2 > 16'hFFFF) ? 16'hFFFF : lo + 2);
    gen_words[p] = WordW'($urandom_range(lo, hi));
    for (int k = p + 1; k < InWords; k++) gen_words[k] = pick_word();
  endtask

  // well-formed streams with random content, plus stray flushes
  task automatic plan_traffic(input int budget);
    int n, m, run_len;
    n = eff_n_words();
    m = eff_m_words(n);
    while (budget > 0) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 12);
      for (int k = 0; k < run_len && budget > 0; k++) begin
        if (!gen_open) begin
          for (int i = 0; i < InWords; i++) gen_words[i] = pick_word();
          gen_open = 1'b1;
        end else begin
          advance_cursor(n, m);
        end
        queue_cursor(pick_count());
        budget--;
      end
      // streams left open carry over, sometimes across a register change
      if ($urandom_range(0, 99) < 70) begin
        queue_beat(flush_beat());
        gen_open = 1'b0;
        budget--;
      end
      if ($urandom_range(0, 99) < 5) begin
        queue_beat(flush_beat());   // flush, with no group open unless the last stream was left open
        gen_open = 1'b0;
        budget--;
      end
    end
  endtask

  // all beats taken, all results back, then let the queue settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (beats_sent != beats_queued || expected_grams.size() != 0);
    repeat (SettlePause) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_config(input logic [CfgW-1:0] n, input logic [CfgW-1:0] m);
    write_reg(CfgNWords, n);
    write_reg(CfgMWords, m);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    n_setting = n;
    m_setting = m;
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  int err_pos;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset registers (n=3, m=2)
    queue_beat(flush_beat());                                           // nothing open
    queue_beat(record_beat(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0));
    queue_beat(record_beat(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h1));  // repeat
    queue_beat(record_beat(16'h0, 16'h0, 16'h5, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF));
    queue_beat(record_beat(16'h0, 16'h0, 16'h6, 16'h0, 16'h0, 16'h0, 32'h5));  // stays sat
    queue_beat(record_beat(16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 32'h7));  // new prefix
    queue_beat(record_beat(16'h0, 16'h1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h3));
    // ids past n drop back to zero: ignored, no order error
    queue_beat(record_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0,
                           32'hFFFF_FFFE));
    queue_beat(record_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 32'h1));
    queue_beat(record_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 32'h1));
    queue_beat(flush_beat());
    queue_beat(flush_beat());                                           // already flushed
    // fresh stream below the old one is legal after a flush
    queue_beat(record_beat(16'h1, 16'h2, 16'h3, 16'hAAAA, 16'h5555, 16'h1, 32'h9));
    queue_beat(record_beat(16'h1, 16'h3, 16'h0, 16'h5555, 16'hAAAA, 16'h0, 32'h1));
    queue_beat(flush_beat());
    wait_idle();

    // random phases, register table first then random settings
    for (int ph = 0; ph < TablePhases + RandomPhases; ph++) begin
      if (ph < TablePhases)
        set_config(CfgW'(n_plan[ph]), CfgW'(m_plan[ph]));
      else
        set_config(CfgW'($urandom_range(0, 7)), CfgW'($urandom_range(0, 7)));
      plan_traffic(PhaseBeats);
      wait_idle();
    end

    // last phase: a few streams, then one order error halts the block
    set_config(CfgW'($urandom_range(2, 6)), CfgW'($urandom_range(0, 7)));
    plan_traffic(40);
    queue_beat(flush_beat());
    for (int i = 0; i < InWords; i++) gen_words[i] = 16'h8000;
    queue_cursor(pick_count());
    queue_cursor(pick_count());
    err_pos = $urandom_range(0, eff_n_words() - 1);
    gen_words[err_pos] = 16'h7FFF;
    for (int k = err_pos + 1; k < InWords; k++) gen_words[k] = pick_word();
    queue_cursor(pick_count());
    // everything after the error must be swallowed
    for (int i = 0; i < InWords; i++) gen_words[i] = pick_word();
    queue_cursor(pick_count());
    queue_beat(flush_beat());
    queue_cursor(pick_count());
    queue_beat(flush_beat());

    do @(posedge clk_i); while (beats_sent != beats_queued);
    draining = 1'b1;
    do @(posedge clk_i); while (expected_grams.size() != 0);
    repeat (SettlePause + 4) @(posedge clk_i);

    if (expected_grams.size() != 0) begin
      bad_grams += expected_grams.size();
      $display("ERROR: %0d predicted results never arrived", expected_grams.size());
    end
    $display("Covered %0d record/flush beats over %0d register settings, ending in a halt.",
             beats_sent, settings_applied);
    $display("Checked %0d result beats, %0d bad.", grams_seen, bad_grams);
    if (bad_grams == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * 10);
    $display("ERROR: timeout, %0d of %0d beats sent, %0d results pending",
             beats_sent, beats_queued, expected_grams.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
